// File: rtl/edge_trigger_ring_capture_assert.svh
// assertion macros shared by the capture block rtl
`ifndef EDGE_TRIGGER_RING_CAPTURE_ASSERT_SVH
`define EDGE_TRIGGER_RING_CAPTURE_ASSERT_SVH

// combinational invariant checked at every rising clock edge out of reset
`define ETRC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the same cycle
`define ETRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define ETRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/etrc_pkg.sv
// shared constants and codes for the edge trigger ring capture block
package etrc_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int ENTRY_W    = SAMPLE_W + TIME_W;
  localparam int FUNC_W     = 3;
  localparam int EDGE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SAMPLE_W;

  // mid-scale trigger level after reset
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = SAMPLE_W'(2048);

  // command codes carried by each transfer
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_t;

  // trigger edge rules
  typedef enum logic [EDGE_W-1:0] {
    EDGE_RISE   = 2'd0,
    EDGE_FALL   = 2'd1,
    EDGE_EITHER = 2'd2
  } edge_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_EN    = 2'd0,
    CFG_TRIG_LEVEL = 2'd1,
    CFG_TRIG_EDGE  = 2'd2
  } cfg_idx_t;

  // status reported with each result
  typedef struct packed {
    logic              stored;
    logic              fired;
    logic              running;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] start_pos;
  } status_t;

endpackage

// File: rtl/etrc_ram.sv
// generic simple dual port ram with registered read
module etrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/edge_trigger_ring_capture.sv
// edge triggered capture block: trigger logic, ring pointers and sample store
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// sample, start, stop, read entry or clear pointers. Every accepted command
// returns exactly one result on the output channel (out_valid / out_stall)
// with the status after the command and, for a read, the stored entry.
// Configuration (trigger enable, level, edge rule) is written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write it only while no
// command is in flight, as the block itself does not enforce this.
// The store read port and stage a load when a command is accepted, and the
// output register loads from stage a when it is empty or not stalled.
// A new command is taken every cycle while in_stall is low; the store
// takes one write and one read per cycle and the pointer update
// completes in the cycle of acceptance.
// When the receiver stalls, the output register holds its result and the
// stage behind it still takes one more command; in_stall rises only when
// both are full. Synchronous reset clears pointers, trigger and capture
// state and sets the level to mid-scale; store contents are not cleared
// and an entry reads as undefined until it has been written.
module edge_trigger_ring_capture (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [etrc_pkg::FUNC_W-1:0]      in_func,
  input  logic [etrc_pkg::SAMPLE_W-1:0]    in_sample_value,
  input  logic [etrc_pkg::TIME_W-1:0]      in_sample_time,
  input  logic [etrc_pkg::ADDR_W-1:0]      in_read_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_stored,
  output logic                             out_trigger_seen,
  output logic                             out_running,
  output logic [etrc_pkg::CNT_W-1:0]       out_count_valid,
  output logic [etrc_pkg::ADDR_W-1:0]      out_start_pos,
  output logic [etrc_pkg::SAMPLE_W-1:0]    out_read_value,
  output logic [etrc_pkg::TIME_W-1:0]      out_read_time,
  input  logic                             cfg_wr_en,
  input  logic [etrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import etrc_pkg::*;

  // configuration registers
  logic                trig_en_r, trig_en_nxt;
  logic [SAMPLE_W-1:0] trig_level_r, trig_level_nxt;
  logic [EDGE_W-1:0]   trig_edge_r, trig_edge_nxt;

  // capture state
  logic [ADDR_W-1:0]   write_pos_r, write_pos_nxt;
  logic [CNT_W-1:0]    valid_total_r, valid_total_nxt;
  logic [ADDR_W-1:0]   oldest_pos_r, oldest_pos_nxt;
  logic [SAMPLE_W-1:0] prev_armed_r, prev_armed_nxt;
  logic                fired_r, fired_nxt;
  logic                capture_on_r, capture_on_nxt;

  // pipeline stages
  logic                a_valid_r;
  status_t             a_status_r;
  logic                a_is_read_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SAMPLE_W-1:0] out_read_value_r;
  logic [TIME_W-1:0]   out_read_time_r;

  // handshake and store access
  logic                out_ready;
  logic                a_move;
  logic                in_fire;
  logic                take;
  logic                is_read;
  logic                hit;
  logic                rise;
  logic                fall;
  logic [ADDR_W-1:0]   base_pos;
  logic [CNT_W-1:0]    base_cnt;
  logic [ADDR_W-1:0]   base_old;
  logic [ADDR_W-1:0]   pos_inc;
  logic                ram_wen;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ring_full;

  // handshake: output register plus one stage behind it
  assign out_ready = !out_valid_r || !out_stall;
  assign a_move    = a_valid_r && out_ready;
  assign in_stall  = a_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  // trigger edge detection against the previous armed sample
  always_comb begin
    rise = (prev_armed_r <= trig_level_r) && (in_sample_value > trig_level_r);
    fall = (prev_armed_r >= trig_level_r) && (in_sample_value < trig_level_r);
    case (trig_edge_r)
      EDGE_RISE:   hit = rise;
      EDGE_FALL:   hit = fall;
      EDGE_EITHER: hit = rise || fall;
      default:     hit = 1'b0;
    endcase
  end

  // command decode and next state
  always_comb begin
    trig_en_nxt     = trig_en_r;
    trig_level_nxt  = trig_level_r;
    trig_edge_nxt   = trig_edge_r;
    write_pos_nxt   = write_pos_r;
    valid_total_nxt = valid_total_r;
    oldest_pos_nxt  = oldest_pos_r;
    prev_armed_nxt  = prev_armed_r;
    fired_nxt       = fired_r;
    capture_on_nxt  = capture_on_r;
    take            = 1'b0;
    is_read         = 1'b0;
    base_pos        = write_pos_r;
    base_cnt        = valid_total_r;
    base_old        = oldest_pos_r;

    if (in_fire) begin
      case (in_func)
        FUNC_SAMPLE: begin
          if (capture_on_r) begin
            take = 1'b1;
            // armed: wait for the edge, the firing sample restarts the ring
            if (trig_en_r && !fired_r) begin
              prev_armed_nxt = in_sample_value;
              if (hit) begin
                fired_nxt = 1'b1;
                base_pos  = '0;
                base_cnt  = '0;
                base_old  = '0;
              end else begin
                take = 1'b0;
              end
            end
          end
        end
        FUNC_START: begin
          capture_on_nxt  = 1'b1;
          fired_nxt       = 1'b0;
          write_pos_nxt   = '0;
          valid_total_nxt = '0;
          oldest_pos_nxt  = '0;
        end
        FUNC_STOP: begin
          capture_on_nxt = 1'b0;
        end
        FUNC_READ: begin
          is_read = 1'b1;
        end
        FUNC_CLEAR: begin
          write_pos_nxt   = '0;
          valid_total_nxt = '0;
          oldest_pos_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    // ring pointer advance on a stored sample
    pos_inc = (base_pos == ADDR_W'(DEPTH - 1)) ? '0 : base_pos + ADDR_W'(1);
    if (take) begin
      write_pos_nxt = pos_inc;
      if (base_cnt < CNT_W'(DEPTH)) begin
        valid_total_nxt = base_cnt + CNT_W'(1);
        oldest_pos_nxt  = base_old;
      end else begin
        valid_total_nxt = base_cnt;
        oldest_pos_nxt  = pos_inc;
      end
    end

    // configuration writes
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TRIG_EN: begin
          trig_en_nxt = cfg_wdata[0];
          fired_nxt   = 1'b0;
        end
        CFG_TRIG_LEVEL: begin
          trig_level_nxt = cfg_wdata[SAMPLE_W-1:0];
        end
        CFG_TRIG_EDGE: begin
          trig_edge_nxt = cfg_wdata[EDGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_wen = take;

  // sample store: value in the upper bits, timestamp in the lower
  etrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wen),
    .wr_addr (base_pos),
    .wr_data ({in_sample_value, in_sample_time}),
    .rd_en   (in_fire && is_read),
    .rd_addr (in_read_index),
    .rd_data (ram_rdata)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_en_r     <= 1'b0;
      trig_level_r  <= LEVEL_RESET;
      trig_edge_r   <= EDGE_RISE;
      write_pos_r   <= '0;
      valid_total_r <= '0;
      oldest_pos_r  <= '0;
      prev_armed_r  <= '0;
      fired_r       <= 1'b0;
      capture_on_r  <= 1'b0;
    end else begin
      trig_en_r     <= trig_en_nxt;
      trig_level_r  <= trig_level_nxt;
      trig_edge_r   <= trig_edge_nxt;
      write_pos_r   <= write_pos_nxt;
      valid_total_r <= valid_total_nxt;
      oldest_pos_r  <= oldest_pos_nxt;
      prev_armed_r  <= prev_armed_nxt;
      fired_r       <= fired_nxt;
      capture_on_r  <= capture_on_nxt;
    end
  end

  // stage a: status captured while the store read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_is_read_r          <= is_read;
      a_status_r.stored    <= take;
      a_status_r.fired     <= fired_nxt;
      a_status_r.running   <= capture_on_nxt;
      a_status_r.count     <= valid_total_nxt;
      a_status_r.start_pos <= oldest_pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_status_r <= a_status_r;
      if (a_is_read_r) begin
        out_read_value_r <= ram_rdata[ENTRY_W-1:TIME_W];
        out_read_time_r  <= ram_rdata[TIME_W-1:0];
      end else begin
        out_read_value_r <= '0;
        out_read_time_r  <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stored       = out_status_r.stored;
  assign out_trigger_seen = out_status_r.fired;
  assign out_running      = out_status_r.running;
  assign out_count_valid  = out_status_r.count;
  assign out_start_pos    = out_status_r.start_pos;
  assign out_read_value   = out_read_value_r;
  assign out_read_time    = out_read_time_r;

  // checks
  assign ring_full = (valid_total_r == CNT_W'(DEPTH));

  `include "edge_trigger_ring_capture_assert.svh"

  `ETRC_ASSERT_ALWAYS(a_count_bound, valid_total_r <= CNT_W'(DEPTH), "valid count over depth")
  `ETRC_ASSERT_SAME(a_oldest_zero, !ring_full, oldest_pos_r == '0, "oldest moved before full")
  `ETRC_ASSERT_SAME(a_full_oldest, ring_full, oldest_pos_r == write_pos_r, "oldest off write pos")
  `ETRC_ASSERT_SAME(a_store_running, ram_wen, capture_on_r && in_fire, "store write while stopped")
  `ETRC_ASSERT_NEXT(a_store_counts, ram_wen, valid_total_r != '0, "stored sample not counted")

endmodule

// File: dv/tb.sv
// self-checking testbench for the edge trigger ring capture block
module tb;
  import etrc_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int QUEUE_AHEAD    = 8;
  localparam int FILL_ITEMS     = 420;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 25;

  // func codes the block leaves unused, status only
  localparam logic [FUNC_W-1:0]   FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0]   FUNC_SPARE_LAST  = 3'd7;
  // edge rule code with no meaning, never fires
  localparam logic [EDGE_W-1:0]   EDGE_NONE        = 2'd3;
  localparam logic [SAMPLE_W-1:0] CODE_MAX         = '1;
  localparam logic [TIME_W-1:0]   STAMP_MAX        = '1;

  typedef struct {
    logic [FUNC_W-1:0]   op;
    logic [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]   stamp;
    logic [ADDR_W-1:0]   index;
  } cmd_t;

  typedef struct {
    logic                stored;
    logic                fired;
    logic                running;
    logic [CNT_W-1:0]    count;
    logic [ADDR_W-1:0]   start_pos;
    logic [SAMPLE_W-1:0] rd_value;
    logic [TIME_W-1:0]   rd_stamp;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func = FUNC_SAMPLE;
  logic [SAMPLE_W-1:0]   in_sample_value = '0;
  logic [TIME_W-1:0]     in_sample_time = '0;
  logic [ADDR_W-1:0]     in_read_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_stored;
  logic                  out_trigger_seen;
  logic                  out_running;
  logic [CNT_W-1:0]      out_count_valid;
  logic [ADDR_W-1:0]     out_start_pos;
  logic [SAMPLE_W-1:0]   out_read_value;
  logic [TIME_W-1:0]     out_read_time;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TRIG_EN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  edge_trigger_ring_capture uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_sample_value  (in_sample_value),
    .in_sample_time   (in_sample_time),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stored       (out_stored),
    .out_trigger_seen (out_trigger_seen),
    .out_running      (out_running),
    .out_count_valid  (out_count_valid),
    .out_start_pos    (out_start_pos),
    .out_read_value   (out_read_value),
    .out_read_time    (out_read_time),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // predicted capture state
  logic [SAMPLE_W-1:0] ring_val [DEPTH];
  logic [TIME_W-1:0]   ring_stamp [DEPTH];
  logic [ADDR_W-1:0]   wr_ptr = '0;
  logic [CNT_W-1:0]    fill_cnt = '0;
  logic [ADDR_W-1:0]   oldest = '0;
  logic [SAMPLE_W-1:0] last_armed = '0;
  logic                fired = 1'b0;
  logic                capturing = 1'b0;
  logic                trig_on = 1'b0;
  logic [SAMPLE_W-1:0] trig_level = LEVEL_RESET;
  logic [EDGE_W-1:0]   trig_rule = EDGE_RISE;

  // positions holding a real sample, safe to read back
  bit                  ever_written [DEPTH];
  int                  written_pos [$];

  cmd_t                pending_cmds [$];
  report_t             expected_reports [$];
  int                  mismatches = 0;
  int                  idle_run = 0;
  bit                  in_took = 1'b0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_asks = 0;
  int                  hold_served = 0;
  int                  hold_left = 0;
  logic [SAMPLE_W-1:0] gen_level = LEVEL_RESET;

  function automatic void clear_ring();
    wr_ptr = '0;
    fill_cnt = '0;
    oldest = '0;
  endfunction

  // armed compare against the level, always tracks the last armed sample
  function automatic logic edge_hit(logic [SAMPLE_W-1:0] v);
    logic rise;
    logic fall;
    logic hit;
    rise = (last_armed <= trig_level) && (v > trig_level);
    fall = (last_armed >= trig_level) && (v < trig_level);
    case (trig_rule)
      EDGE_RISE:   hit = rise;
      EDGE_FALL:   hit = fall;
      EDGE_EITHER: hit = rise || fall;
      default:     hit = 1'b0;
    endcase
    last_armed = v;
    return hit;
  endfunction

  function automatic report_t predict_capture(cmd_t c);
    report_t r;
    logic    take;
    r = '{default: 0};
    case (c.op)
      FUNC_SAMPLE: begin
        take = capturing;
        if (take && trig_on && !fired) begin
          take = edge_hit(c.value);
          // firing sample restarts the ring
          if (take) begin
            fired = 1'b1;
            clear_ring();
          end
        end
        if (take) begin
          ring_val[wr_ptr] = c.value;
          ring_stamp[wr_ptr] = c.stamp;
          if (!ever_written[wr_ptr]) begin
            ever_written[wr_ptr] = 1'b1;
            written_pos.push_back(wr_ptr);
          end
          wr_ptr = (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          // once full the oldest entry sits at the write position
          if (fill_cnt < DEPTH) fill_cnt = fill_cnt + 1'b1;
          else oldest = wr_ptr;
        end
        r.stored = take;
      end
      FUNC_START: begin
        capturing = 1'b1;
        fired = 1'b0;
        clear_ring();
      end
      FUNC_STOP: capturing = 1'b0;
      FUNC_READ: begin
        r.rd_value = ring_val[c.index];
        r.rd_stamp = ring_stamp[c.index];
      end
      FUNC_CLEAR: clear_ring();
      default: ;
    endcase
    r.fired = fired;
    r.running = capturing;
    r.count = fill_cnt;
    r.start_pos = oldest;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: config tracking, result checking, prediction, watchdog
  always @(posedge clk) begin : monitor
    report_t want;
    cmd_t    c;
    in_took = 1'b0;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TRIG_EN: begin
            trig_on = cfg_wdata[0];
            fired = 1'b0;
          end
          CFG_TRIG_LEVEL: trig_level = cfg_wdata;
          CFG_TRIG_EDGE:  trig_rule = cfg_wdata[EDGE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result transfer with no command pending", $time);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("stored", want.stored, out_stored);
          check_field("trigger_seen", want.fired, out_trigger_seen);
          check_field("running", want.running, out_running);
          check_field("count_valid", want.count, out_count_valid);
          check_field("start_pos", want.start_pos, out_start_pos);
          check_field("read_value", want.rd_value, out_read_value);
          check_field("read_time", want.rd_stamp, out_read_time);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        c.op = in_func;
        c.value = in_sample_value;
        c.stamp = in_sample_time;
        c.index = in_read_index;
        expected_reports.push_back(predict_capture(c));
      end
      if (in_took || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_run);
        $display("** edge_trigger_ring_capture: FAILED **");
        $finish;
      end
    end
  end

  // command driver: holds a stalled transfer, otherwise offers or idles
  always @(negedge clk) begin : driver
    if (in_took) void'(pending_cmds.pop_front());
    if (in_valid && !in_took) begin
      // payload held until taken
    end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid        <= 1'b1;
      in_func         <= pending_cmds[0].op;
      in_sample_value <= pending_cmds[0].value;
      in_sample_time  <= pending_cmds[0].stamp;
      in_read_index   <= pending_cmds[0].index;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin : receiver
    if (hold_asks != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served = hold_asks;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_cmd(logic [FUNC_W-1:0] op, logic [SAMPLE_W-1:0] value,
                          logic [TIME_W-1:0] stamp, logic [ADDR_W-1:0] index);
    cmd_t c;
    while (pending_cmds.size() >= QUEUE_AHEAD) @(posedge clk);
    c.op = op;
    c.value = value;
    c.stamp = stamp;
    c.index = index;
    pending_cmds.push_back(c);
  endtask

  task automatic push_op(logic [FUNC_W-1:0] op, logic [SAMPLE_W-1:0] value);
    push_cmd(op, value, TIME_W'($urandom), ADDR_W'($urandom));
  endtask

  // sample codes biased to the extremes and to the trigger level
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = CODE_MAX;
      2, 3, 4, 5, 6: v = int'(gen_level) + int'($urandom_range(0, 8)) - 4;
      default: v = $urandom_range(0, CODE_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > CODE_MAX) v = CODE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // read only positions that already hold a sample
  task automatic push_read();
    if (written_pos.size() == 0) begin
      push_op(FUNC_SAMPLE, pick_sample());
    end else begin
      push_cmd(FUNC_READ, SAMPLE_W'($urandom), TIME_W'($urandom),
               ADDR_W'(written_pos[$urandom_range(0, written_pos.size() - 1)]));
    end
  endtask

  // one capture session: mostly samples and reads, some breaks and noise
  task automatic gen_capture(int n);
    int roll;
    push_op(FUNC_START, SAMPLE_W'($urandom));
    for (int k = 1; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 68) begin
        push_op(FUNC_SAMPLE, pick_sample());
      end else if (roll < 80) begin
        push_read();
      end else if (roll < 84) begin
        push_op(FUNC_CLEAR, SAMPLE_W'($urandom));
      end else if (roll < 88) begin
        push_op(FUNC_STOP, SAMPLE_W'($urandom));
        push_op(FUNC_SAMPLE, pick_sample());
        push_op(FUNC_START, SAMPLE_W'($urandom));
        k += 2;
      end else if (roll < 92) begin
        push_op(FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                SAMPLE_W'($urandom));
      end else if (roll < 95) begin
        push_op(FUNC_START, SAMPLE_W'($urandom));
      end else begin
        push_op(FUNC_SAMPLE, SAMPLE_W'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // program all three registers once the block has drained
  task automatic set_trigger(logic en, logic [SAMPLE_W-1:0] level,
                             logic [EDGE_W-1:0] rule);
    logic [CFG_DATA_W-1:0] noise;
    wait_idle();
    noise = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TRIG_EN;
    cfg_wdata <= {noise[CFG_DATA_W-1:1], en};
    @(negedge clk);
    cfg_index <= CFG_TRIG_LEVEL;
    cfg_wdata <= level;
    @(negedge clk);
    cfg_index <= CFG_TRIG_EDGE;
    cfg_wdata <= {noise[CFG_DATA_W-1:EDGE_W], rule};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gen_level = level;
  endtask

  task automatic set_idling(int mode);
    @(posedge clk);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 75; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 75; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, trigger off: stopped samples, spare codes, extremes
    push_op(FUNC_SAMPLE, SAMPLE_W'($urandom));
    for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
      push_op(f[FUNC_W-1:0], SAMPLE_W'($urandom));
    push_op(FUNC_STOP, SAMPLE_W'($urandom));
    push_op(FUNC_CLEAR, SAMPLE_W'($urandom));
    push_op(FUNC_START, SAMPLE_W'($urandom));
    push_cmd(FUNC_SAMPLE, '0, '0, '0);
    push_cmd(FUNC_SAMPLE, CODE_MAX, STAMP_MAX, '1);
    push_cmd(FUNC_READ, SAMPLE_W'($urandom), TIME_W'($urandom), ADDR_W'(0));
    push_cmd(FUNC_READ, SAMPLE_W'($urandom), TIME_W'($urandom), ADDR_W'(1));
    push_op(FUNC_CLEAR, SAMPLE_W'($urandom));
    push_op(FUNC_SAMPLE, pick_sample());
    push_op(FUNC_STOP, SAMPLE_W'($urandom));
    push_op(FUNC_SAMPLE, pick_sample());

    // rising edge just above mid-scale fires and restarts the ring
    set_trigger(1'b1, LEVEL_RESET, EDGE_RISE);
    push_op(FUNC_START, SAMPLE_W'($urandom));
    push_op(FUNC_SAMPLE, LEVEL_RESET);
    push_op(FUNC_SAMPLE, LEVEL_RESET + 1'b1);
    push_op(FUNC_SAMPLE, pick_sample());

    // falling edge while still running, after a re-arm by register write
    set_trigger(1'b1, LEVEL_RESET, EDGE_FALL);
    push_op(FUNC_SAMPLE, LEVEL_RESET);
    push_op(FUNC_SAMPLE, LEVEL_RESET - 1'b1);
    push_cmd(FUNC_READ, SAMPLE_W'($urandom), TIME_W'($urandom), ADDR_W'(0));

    // long untriggered capture: back to back samples with some read-backs
    set_trigger(1'b0, SAMPLE_W'($urandom), EDGE_W'($urandom));
    set_idling(0);
    push_op(FUNC_START, SAMPLE_W'($urandom));
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 94) push_op(FUNC_SAMPLE, SAMPLE_W'($urandom));
      else push_read();
    end

    // random sessions over several trigger settings and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_trigger(1'b1, '0, EDGE_RISE);
        1: set_trigger(1'b1, CODE_MAX, EDGE_FALL);
        2: set_trigger(1'b1, LEVEL_RESET, EDGE_EITHER);
        3: set_trigger(1'b1, SAMPLE_W'($urandom), EDGE_NONE);
        4: set_trigger(1'b0, SAMPLE_W'($urandom), EDGE_W'($urandom));
        5: set_trigger(1'b1, CODE_MAX, EDGE_RISE);
        default: set_trigger($urandom_range(0, 3) != 0, SAMPLE_W'($urandom),
                             EDGE_W'($urandom));
      endcase
      set_idling(p % 4);
      // receiver holds off while the sender keeps offering
      if (p == 0) hold_asks++;
      gen_capture(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("** edge_trigger_ring_capture: PASSED **");
    end else begin
      $display("** edge_trigger_ring_capture: FAILED **");
    end
    $finish;
  end

endmodule
